### sv/bfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon frame parser package
// Shared payload types, result status codes and frame layout constants.
// ----------------------------------------------------------------------------
package bfp_pkg;

    // Frame layout: two reserved bytes, four time bytes, CRC low and high,
    // descriptor, then eight info bytes.
    localparam int unsigned FRAME_BYTES   = 17;
    localparam int unsigned CRC_SPAN      = 6;
    localparam int unsigned POS_W         = 5;

    localparam logic [POS_W-1:0] POS_TIME_FIRST = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CRC_LOW    = POS_W'(CRC_SPAN);
    localparam logic [POS_W-1:0] POS_CRC_HIGH   = POS_W'(CRC_SPAN + 1);
    localparam logic [POS_W-1:0] POS_DESC       = POS_W'(CRC_SPAN + 2);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);

    // Descriptors below this value carry coordinates.
    localparam logic [7:0] DESC_COORD_LIMIT = 8'd3;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_CRC_ERR  = 2'd1,
        STATUS_TIME_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        first_byte;
        logic [31:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] beacon_time;
        logic [7:0]  info_descriptor;
        logic        coords_valid;
        logic [23:0] latitude;
        logic [23:0] longitude;
        logic [47:0] info_field;
    } t_out_item;

endpackage

### sv/bfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon frame parser channels
// Valid/ready channels for incoming frame bytes and outgoing parse results.
// ----------------------------------------------------------------------------
interface bfp_in_if;
    logic               valid;
    logic               ready;
    bfp_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bfp_out_if;
    logic               valid;
    logic               ready;
    bfp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/bfp_crc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon frame parser CRC step
// Folds one byte into the 16-bit beacon CRC accumulator.
// ----------------------------------------------------------------------------
module bfp_crc_step (
    input  logic [15:0] i_acc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_acc
);
    always_comb begin
        logic [15:0] a;
        a = i_acc ^ {8'h00, i_byte};
        a = {a[7:0], a[15:8]};
        a = a ^ ((a & 16'hff00) << 4);
        a = a ^ (a >> 12);
        a = a ^ ((a & 16'hff00) >> 5);
        o_acc = a;
    end
endmodule

### sv/beacon_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon frame parser
// Parses a 17-byte beacon frame arriving one byte per transfer.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per clock cycle and produces at most one
// result per frame. Each accepted byte updates the frame state in the cycle
// it is accepted, and any result it causes is held in an output register from
// the next cycle until the sink takes it. The input is ready whenever that
// output register is empty or is being emptied in the same cycle, so bytes
// stream at one per cycle as long as results are drained. A byte with
// first_byte set always starts a new frame and abandons any frame in
// progress. A CRC mismatch or a beacon time later than now_seconds (sampled
// with the high CRC byte, frame byte 7) produces an error result at that
// byte; a good result is produced at the last byte, frame byte 16. Unmarked
// bytes after a result, or before any marked byte, are discarded.
// ----------------------------------------------------------------------------
module beacon_frame_parser (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bfp_in_if.sink   i_frame,
    bfp_out_if.source o_result
);
    import bfp_pkg::*;

    // Frame state.
    logic [POS_W-1:0] r_pos,      n_pos;
    logic [15:0]      r_crc,      n_crc;
    logic [31:0]      r_time,     n_time;
    logic [7:0]       r_crc_low,  n_crc_low;
    logic [7:0]       r_desc,     n_desc;
    logic [47:0]      r_info,     n_info;
    logic             r_drop,     n_drop;

    // Result register.
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out,       n_out;

    logic             accept;
    logic             emit;
    logic [15:0]      crc_base;
    logic [15:0]      crc_next;
    logic             coords;

    assign i_frame.ready  = !r_out_valid || o_result.ready;
    assign accept         = i_frame.valid && i_frame.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // A marked byte restarts the CRC from zero.
    assign crc_base = i_frame.data.first_byte ? 16'h0000 : r_crc;

    bfp_crc_step u_crc (
        .i_acc  (crc_base),
        .i_byte (i_frame.data.frame_byte),
        .o_acc  (crc_next)
    );

    assign coords = r_desc < DESC_COORD_LIMIT;

    always_comb begin
        logic [POS_W-1:0] pos;
        logic [31:0]      tim;
        logic [7:0]       clo;
        logic [7:0]       dsc;
        logic [47:0]      inf;
        logic             drp;
        logic [7:0]       b;

        b   = i_frame.data.frame_byte;
        pos = i_frame.data.first_byte ? '0 : r_pos;
        tim = i_frame.data.first_byte ? '0 : r_time;
        clo = i_frame.data.first_byte ? '0 : r_crc_low;
        dsc = i_frame.data.first_byte ? '0 : r_desc;
        inf = i_frame.data.first_byte ? '0 : r_info;
        drp = i_frame.data.first_byte ? 1'b0 : r_drop;

        n_pos     = r_pos;
        n_crc     = r_crc;
        n_time    = r_time;
        n_crc_low = r_crc_low;
        n_desc    = r_desc;
        n_info    = r_info;
        n_drop    = r_drop;
        emit      = 1'b0;
        n_out     = '0;

        if (accept && !drp) begin
            n_pos     = pos + POS_W'(1);
            n_crc     = crc_base;
            n_time    = tim;
            n_crc_low = clo;
            n_desc    = dsc;
            n_info    = inf;
            n_drop    = 1'b0;

            if (pos < POS_CRC_LOW) begin
                n_crc = crc_next;
                if (pos >= POS_TIME_FIRST) begin
                    n_time = {tim[23:0], b};
                end
            end else if (pos == POS_CRC_LOW) begin
                n_crc_low = b;
            end else if (pos == POS_CRC_HIGH) begin
                if ({b, clo} != crc_base) begin
                    n_drop       = 1'b1;
                    emit         = 1'b1;
                    n_out.status = STATUS_CRC_ERR;
                end else if (i_frame.data.now_seconds < tim) begin
                    n_drop       = 1'b1;
                    emit         = 1'b1;
                    n_out.status = STATUS_TIME_ERR;
                end
            end else if (pos == POS_DESC) begin
                n_desc = b;
            end else begin
                // Info bytes arrive low byte first; only the upper six bytes
                // of the word are kept, so the lowest two shift out.
                n_info = {b, inf[47:8]};
                if (pos == POS_LAST) begin
                    n_drop                = 1'b1;
                    emit                  = 1'b1;
                    n_out.status          = STATUS_GOOD;
                    n_out.beacon_time     = tim;
                    n_out.info_descriptor = dsc;
                    n_out.coords_valid    = coords;
                    n_out.info_field      = {b, inf[47:8]};
                    if (coords) begin
                        n_out.latitude  = n_out.info_field[47:24];
                        n_out.longitude = n_out.info_field[23:0];
                    end
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept && emit) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= '0;
            r_time      <= '0;
            r_crc_low   <= '0;
            r_desc      <= '0;
            r_info      <= '0;
            r_drop      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_time      <= n_time;
            r_crc_low   <= n_crc_low;
            r_desc      <= n_desc;
            r_info      <= n_info;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // The result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= n_out;
        end
    end

endmodule
